// ===== src/ide_cartridge_bus_bridge_assert.svh =====
// Assertion macros shared by the bridge checker.
`ifndef IDE_CARTRIDGE_BUS_BRIDGE_ASSERT_SVH
`define IDE_CARTRIDGE_BUS_BRIDGE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define IBB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bridge assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define IBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bridge assertion failed");

`endif

// ===== src/ibb_pkg.sv =====
// Types and constants of the IDE cartridge bus bridge.
`timescale 1ns / 1ps
package ibb_pkg;

  // Access kind codes.
  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // Address decodes.
  localparam logic [15:0] CtrlMask    = 16'hBF04;
  localparam logic [15:0] CtrlMatch   = 16'h0104;
  localparam logic [15:0] DataWinMask = 16'h3E00;
  localparam logic [15:0] DataWinBase = 16'h3C00;
  localparam logic [15:0] RegWinMask  = 16'h3F00;
  localparam logic [15:0] RegWinBase  = 16'h3E00;

  // IDE register numbers.
  localparam logic [3:0] RegData      = 4'd0;
  localparam logic [3:0] RegDevHead   = 4'd6;
  localparam logic [3:0] RegStatus    = 4'd7;
  localparam logic [3:0] RegSoftReset = 4'd14;

  // Bit positions and answer bytes.
  localparam int unsigned DevBit       = 4;
  localparam int unsigned SoftResetBit = 2;
  localparam logic [7:0]  StatusBusy   = 8'hFF;
  localparam logic [7:0]  OtherBusy    = 8'h7F;
  localparam logic [7:0]  OpenBus      = 8'hFF;
  localparam logic [7:0]  CtrlReset    = 8'hFF;
  localparam logic [5:0]  BankCountReset = 6'd8;

  // One CPU bus request.
  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] ide_data_in;
  } item_t;

  // One bridge result.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_from_rom;
    logic [18:0] rom_address;
    logic        ide_strobe;
    logic        ide_write;
    logic [3:0]  ide_register;
    logic        ide_device;
    logic [15:0] ide_write_data;
    logic        ide_reset;
  } result_t;

endpackage

// ===== src/ibb_in_stage.sv =====
// Input register stage of the bridge.
`timescale 1ns / 1ps
module ibb_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ibb_pkg::item_t in_item,
  input  logic           load_ok,
  output logic           advance,
  output ibb_pkg::item_t item
);
  import ibb_pkg::*;

  logic held;

  // The held request moves on whenever the result register can take it.
  assign advance  = held & load_ok;
  assign in_stall = held & ~load_ok;

  // Capture a new request whenever the stage is empty or emptying.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end
endmodule

// ===== src/ibb_core.sv =====
// Decode logic and bridge state: control byte, latches, device select, soft reset.
`timescale 1ns / 1ps
module ibb_core #(
  parameter int MAX_ROM_BANKS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [5:0]       cfg_wr_data,
  input  logic             advance,
  input  ibb_pkg::item_t   item,
  output ibb_pkg::result_t result
);
  import ibb_pkg::*;

  localparam logic [5:0] MaxBanks = 6'(MAX_ROM_BANKS);

  logic [5:0] rom_bank_count;
  logic [7:0] control_byte, control_byte_next;
  logic [7:0] read_high_latch, read_high_latch_next;
  logic [7:0] write_low_latch, write_low_latch_next;
  logic       device_select, device_select_next;
  logic       soft_reset_active, soft_reset_active_next;

  logic       enabled, data_win, reg_win, ctrl_hit, rom_hit;
  logic [3:0] reg_num, reg_read;
  logic [4:0] bank_raw, bank;
  logic [5:0] count_sat, count_eff;
  logic [4:0] count_mask;

  // Window decodes.
  assign enabled  = control_byte[0];
  assign data_win = enabled && ((item.address & DataWinMask) == DataWinBase);
  assign reg_win  = enabled && ((item.address & RegWinMask) == RegWinBase);
  assign ctrl_hit = (item.address & CtrlMask) == CtrlMatch;
  assign rom_hit  = item.address[15:14] == 2'b01;
  assign reg_num  = item.address[3:0];
  assign reg_read = (reg_num == RegSoftReset) ? RegStatus : reg_num;

  // Bank select: bit-reversed control bits, masked to the bank count.
  assign bank_raw   = {control_byte[3], control_byte[4], control_byte[5],
                       control_byte[6], control_byte[7]};
  assign count_sat  = (rom_bank_count > MaxBanks) ? MaxBanks : rom_bank_count;
  assign count_eff  = (count_sat == 6'd0) ? 6'd1 : count_sat;
  assign count_mask = 5'(count_eff - 6'd1);
  assign bank       = ({1'b0, bank_raw} >= count_eff) ? (bank_raw & count_mask) : bank_raw;

  // Request decode and next-state logic.
  always_comb begin
    result                 = '0;
    control_byte_next      = control_byte;
    read_high_latch_next   = read_high_latch;
    write_low_latch_next   = write_low_latch;
    device_select_next     = device_select;
    soft_reset_active_next = soft_reset_active;

    if (item.kind == KindRead) begin
      if (data_win) begin
        if (!item.address[0]) begin
          result.ide_strobe    = 1'b1;
          result.read_data     = item.ide_data_in[7:0];
          read_high_latch_next = item.ide_data_in[15:8];
        end else begin
          result.read_data = read_high_latch;
        end
      end else if (reg_win) begin
        if (soft_reset_active) begin
          result.read_data = (reg_read == RegStatus) ? StatusBusy : OtherBusy;
        end else begin
          result.ide_strobe   = 1'b1;
          result.ide_register = reg_read;
          result.read_data    = item.ide_data_in[7:0];
          if (reg_read == RegDevHead) begin
            result.read_data[DevBit] = device_select;
          end
        end
      end else if (rom_hit) begin
        result.read_from_rom = 1'b1;
        result.rom_address   = {bank, item.address[13:0]};
      end else begin
        result.read_data = OpenBus;
      end
    end else begin
      if (ctrl_hit) begin
        control_byte_next = item.write_data;
      end else if (data_win) begin
        if (!item.address[0]) begin
          write_low_latch_next = item.write_data;
        end else begin
          result.ide_strobe     = 1'b1;
          result.ide_write      = 1'b1;
          result.ide_write_data = {item.write_data, write_low_latch};
        end
      end else if (reg_win) begin
        if (soft_reset_active) begin
          if (reg_num == RegSoftReset && !item.write_data[SoftResetBit]) begin
            soft_reset_active_next = 1'b0;
          end
        end else if (reg_num == RegData) begin
          result.ide_strobe     = 1'b1;
          result.ide_write      = 1'b1;
          result.ide_write_data = {item.write_data, item.write_data};
        end else if (reg_num == RegSoftReset && item.write_data[SoftResetBit]) begin
          soft_reset_active_next = 1'b1;
          result.ide_reset       = 1'b1;
        end else begin
          if (reg_num == RegDevHead) begin
            device_select_next = item.write_data[DevBit];
          end
          result.ide_strobe     = 1'b1;
          result.ide_write      = 1'b1;
          result.ide_register   = reg_num;
          result.ide_write_data = {8'h00, item.write_data};
        end
      end
    end

    result.ide_device = device_select_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= BankCountReset;
    end else if (cfg_wr_en) begin
      rom_bank_count <= cfg_wr_data;
    end
  end

  // State moves when the request leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte      <= CtrlReset;
      read_high_latch   <= 8'h00;
      write_low_latch   <= 8'h00;
      device_select     <= 1'b0;
      soft_reset_active <= 1'b0;
    end else if (advance) begin
      control_byte      <= control_byte_next;
      read_high_latch   <= read_high_latch_next;
      write_low_latch   <= write_low_latch_next;
      device_select     <= device_select_next;
      soft_reset_active <= soft_reset_active_next;
    end
  end
endmodule

// ===== src/ibb_out_stage.sv =====
// Result register stage of the bridge.
`timescale 1ns / 1ps
module ibb_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ibb_pkg::result_t result_in,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output ibb_pkg::result_t result
);
  import ibb_pkg::*;

  // The register can load when it is empty or its result is taken now.
  assign load_ok = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && advance) begin
      result <= result_in;
    end
  end
endmodule

// ===== src/ide_cartridge_bus_bridge.sv =====
// Top level of the IDE cartridge bus bridge.
`timescale 1ns / 1ps
// The bridge takes one CPU bus request per cycle while in_stall is low and
// returns one result per request: a request is held in the input register
// while the address decode runs, and its result then sits in the result
// register until taken. The control byte, data latches, device select and
// soft-reset flag are updated as a request moves from the input register to
// the result register, so the following request already sees them. Both
// registers pass a new request every cycle while out_stall is low, so the
// sustained rate is one request per clock. The user must write rom_bank_count
// through cfg_wr_en and cfg_wr_data while the bridge is idle (not enforced).
module ide_cartridge_bus_bridge #(
  parameter int MAX_ROM_BANKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [15:0] ide_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        read_from_rom,
  output logic [18:0] rom_address,
  output logic        ide_strobe,
  output logic        ide_write,
  output logic [3:0]  ide_register,
  output logic        ide_device,
  output logic [15:0] ide_write_data,
  output logic        ide_reset
);
  import ibb_pkg::*;

  item_t   in_item, item;
  result_t core_result, result;
  logic    advance, load_ok;

  assign in_item = '{kind: kind, address: address, write_data: write_data,
                     ide_data_in: ide_data_in};

  // Input register.
  ibb_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .load_ok  (load_ok),
    .advance  (advance),
    .item     (item)
  );

  // Decode and state.
  ibb_core #(
    .MAX_ROM_BANKS (MAX_ROM_BANKS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .result      (core_result)
  );

  // Result register.
  ibb_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result_in (core_result),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign read_data      = result.read_data;
  assign read_from_rom  = result.read_from_rom;
  assign rom_address    = result.rom_address;
  assign ide_strobe     = result.ide_strobe;
  assign ide_write      = result.ide_write;
  assign ide_register   = result.ide_register;
  assign ide_device     = result.ide_device;
  assign ide_write_data = result.ide_write_data;
  assign ide_reset      = result.ide_reset;
endmodule

// ===== src/ibb_checker.sv =====
// Port-level checker of the bridge and its bind to the top level.
`timescale 1ns / 1ps
`include "ide_cartridge_bus_bridge_assert.svh"
module ibb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic        read_from_rom,
  input logic [18:0] rom_address,
  input logic        ide_strobe,
  input logic        ide_write,
  input logic [3:0]  ide_register,
  input logic [15:0] ide_write_data,
  input logic        ide_reset
);
  // A stalled result stays offered.
  `IBB_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(read_data))
  // A ROM read carries no bus byte and issues no device access.
  `IBB_ASSERT_NOW(a_rom_quiet, out_valid && read_from_rom, read_data == 8'h00 && !ide_strobe)
  // Without a strobe there is no direction or register set.
  `IBB_ASSERT_NOW(a_idle_fields, out_valid && !ide_strobe, !ide_write && ide_register == 4'd0)
  // Write data and ROM address are driven only for their own requests.
  `IBB_ASSERT_NOW(a_payload_zero, out_valid && !ide_write && !read_from_rom,
                  ide_write_data == 16'h0000 && rom_address == 19'd0 && !(ide_reset && ide_strobe))
endmodule

bind ide_cartridge_bus_bridge ibb_checker u_ibb_checker (.*);
